@@ hw/rtl/spct_pkg.sv @@
// Shared types and constants of the stream packet count table.
package spct_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int STREAM_W      = 64;
    localparam int COUNT_W       = 32;
    localparam int SLOT_OUT_W    = 4;
    localparam int KIND_W        = 3;

    // Result kinds as they appear on the kind port.
    typedef enum logic [KIND_W-1:0] {
        KIND_COUNTED = 3'd0,
        KIND_ADDED   = 3'd1,
        KIND_DROPPED = 3'd2,
        KIND_IGNORED = 3'd3,
        KIND_REPORT  = 3'd4,
        KIND_REMOVED = 3'd5,
        KIND_EMPTY   = 3'd6
    } kind_t;

    // Input action codes.
    typedef enum logic {
        ACT_PACKET = 1'b0,
        ACT_CHECK  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PKT_WR,
        ST_CHECK
    } state_t;

    // One table entry as stored in the RAM.
    typedef struct packed {
        logic [STREAM_W-1:0] sid;
        logic [COUNT_W-1:0]  cnt;
        logic [COUNT_W-1:0]  prev;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result transaction.
    typedef struct packed {
        kind_t                 kind;
        logic [SLOT_OUT_W-1:0] slot;
        logic [STREAM_W-1:0]   stream;
        logic [COUNT_W-1:0]    delta;
        logic                  last;
    } result_t;

endpackage

@@ hw/rtl/stream_packet_count_table.sv @@
// Order: a packet's result follows a scan that reads every slot; a zero id skips the scan;
// a check's first result follows the read of slot 0 and the rest follow one per cycle
// while the result side does not stall.
// Throughput: one transaction at a time; a new request is stalled until the current one is
// done, and a scan makes one table read per cycle from the slot RAM.
// Reset clears the control state and the per-slot valid bits at once, so every slot
// reads as free with zero counts right after reset; no clearing pass is needed.
module stream_packet_count_table #(
    parameter int SLOTS = spct_pkg::SLOTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input transactions.
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                action,
    input  logic [spct_pkg::STREAM_W-1:0]       stream_id,
    // Result transactions.
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [spct_pkg::KIND_W-1:0]         kind,
    output logic [spct_pkg::SLOT_OUT_W-1:0]     slot,
    output logic [spct_pkg::STREAM_W-1:0]       slot_stream,
    output logic [spct_pkg::COUNT_W-1:0]        count_delta,
    output logic                                last
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // The whole table lives in one RAM; each word holds the stream id, the
    // running count and the count captured at the previous check.
    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_wr_addr;
    spct_pkg::entry_t  ram_wr_data;
    logic              ram_rd_en;
    logic [SLOT_W-1:0] ram_rd_addr;
    spct_pkg::entry_t  ram_rd_data;

    logic              res_ready;
    logic              res_valid;
    spct_pkg::result_t res;

    // Output register: it decouples the engine from a stalled result side.
    logic              out_valid_reg;
    spct_pkg::result_t out_reg;

    spct_ram #(
        .WIDTH (spct_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    spct_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_action  (action),
        .req_sid     (stream_id),
        .res_ready   (res_ready),
        .res_valid   (res_valid),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // A new result may load when the register is empty or is being taken.
    assign res_ready = !out_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign slot        = out_reg.slot;
    assign slot_stream = out_reg.stream;
    assign count_delta = out_reg.delta;
    assign last        = out_reg.last;

endmodule

@@ hw/rtl/spct_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module spct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/spct_engine.sv @@
// Sequencer that walks the slot table in RAM for packet and check transactions.
module spct_engine #(
    parameter int SLOTS = spct_pkg::SLOTS_DEFAULT,
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_W  = $clog2(SLOTS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input transaction.
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            req_action,
    input  logic [spct_pkg::STREAM_W-1:0]   req_sid,
    // Result hand-off to the output register.
    input  logic                            res_ready,
    output logic                            res_valid,
    output spct_pkg::result_t               res,
    // Table RAM.
    output logic                            ram_wr_en,
    output logic [SLOT_W-1:0]               ram_wr_addr,
    output spct_pkg::entry_t                ram_wr_data,
    output logic                            ram_rd_en,
    output logic [SLOT_W-1:0]               ram_rd_addr,
    input  spct_pkg::entry_t                ram_rd_data
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  NUM_SLOTS = CNT_W'(SLOTS);

    spct_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic              rd_vld_reg;
    logic [SLOTS-1:0]  vld_reg;

    logic [spct_pkg::STREAM_W-1:0] sid_reg, sid_next;
    logic              match_reg, match_next;
    logic [SLOT_W-1:0] match_slot_reg, match_slot_next;
    spct_pkg::entry_t  match_ent_reg, match_ent_next;
    logic              free_reg, free_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;

    spct_pkg::entry_t          ent;
    logic [spct_pkg::COUNT_W-1:0] delta;
    logic                      is_last;
    logic                      can_emit;
    logic [SLOT_W+3:0]         rd_slot_ext;
    logic [SLOT_W+3:0]         match_slot_ext;
    logic [SLOT_W+3:0]         free_slot_ext;

    // An entry never written since reset reads as all zero.
    assign ent            = rd_vld_reg ? ram_rd_data : '0;
    assign delta          = ent.cnt - ent.prev;
    assign is_last        = (rd_slot_reg == LAST_SLOT);
    assign rd_slot_ext    = {4'b0, rd_slot_reg};
    assign match_slot_ext = {4'b0, match_slot_reg};
    assign free_slot_ext  = {4'b0, free_slot_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= spct_pkg::ST_IDLE;
            issue_reg   <= '0;
            rd_pend_reg <= 1'b0;
            vld_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            rd_pend_reg <= rd_pend_next;
            if (ram_wr_en)
            begin
                vld_reg[ram_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sid_reg        <= sid_next;
        match_reg      <= match_next;
        match_slot_reg <= match_slot_next;
        match_ent_reg  <= match_ent_next;
        free_reg       <= free_next;
        free_slot_reg  <= free_slot_next;
        if (ram_rd_en)
        begin
            rd_slot_reg <= ram_rd_addr;
            rd_vld_reg  <= vld_reg[ram_rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        rd_pend_next    = rd_pend_reg;
        sid_next        = sid_reg;
        match_next      = match_reg;
        match_slot_next = match_slot_reg;
        match_ent_next  = match_ent_reg;
        free_next       = free_reg;
        free_slot_next  = free_slot_reg;
        req_stall       = (state_reg != spct_pkg::ST_IDLE);
        ram_rd_en       = 1'b0;
        ram_rd_addr     = issue_reg[SLOT_W-1:0];
        ram_wr_en       = 1'b0;
        ram_wr_addr     = rd_slot_reg;
        ram_wr_data     = ent;
        res_valid       = 1'b0;
        res             = '0;
        can_emit        = 1'b0;

        unique case (state_reg)
            spct_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    sid_next     = req_sid;
                    issue_next   = '0;
                    rd_pend_next = 1'b0;
                    match_next   = 1'b0;
                    free_next    = 1'b0;
                    if (req_action == spct_pkg::ACT_CHECK)
                    begin
                        state_next = spct_pkg::ST_CHECK;
                    end
                    else if (req_sid == '0)
                    begin
                        state_next = spct_pkg::ST_PKT_WR;
                    end
                    else
                    begin
                        state_next = spct_pkg::ST_SCAN;
                    end
                end
            end

            spct_pkg::ST_SCAN:
            begin
                // One slot read per cycle; compare on the returning data.
                if (issue_reg < NUM_SLOTS)
                begin
                    ram_rd_en  = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                rd_pend_next = ram_rd_en;
                if (rd_pend_reg)
                begin
                    if (!match_reg && ent.sid == sid_reg)
                    begin
                        match_next      = 1'b1;
                        match_slot_next = rd_slot_reg;
                        match_ent_next  = ent;
                    end
                    if (ent.sid == '0)
                    begin
                        free_next      = 1'b1;
                        free_slot_next = rd_slot_reg;
                    end
                    if (is_last)
                    begin
                        state_next = spct_pkg::ST_PKT_WR;
                    end
                end
            end

            spct_pkg::ST_PKT_WR:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    res.last   = 1'b1;
                    state_next = spct_pkg::ST_IDLE;
                    if (sid_reg == '0)
                    begin
                        res.kind = spct_pkg::KIND_IGNORED;
                    end
                    else if (match_reg)
                    begin
                        res.kind         = spct_pkg::KIND_COUNTED;
                        res.slot         = match_slot_ext[3:0];
                        res.stream       = sid_reg;
                        ram_wr_en        = 1'b1;
                        ram_wr_addr      = match_slot_reg;
                        ram_wr_data      = match_ent_reg;
                        ram_wr_data.cnt  = match_ent_reg.cnt + 1'b1;
                    end
                    else if (free_reg)
                    begin
                        res.kind         = spct_pkg::KIND_ADDED;
                        res.slot         = free_slot_ext[3:0];
                        res.stream       = sid_reg;
                        ram_wr_en        = 1'b1;
                        ram_wr_addr      = free_slot_reg;
                        ram_wr_data.sid  = sid_reg;
                        ram_wr_data.cnt  = spct_pkg::COUNT_W'(1);
                        ram_wr_data.prev = '0;
                    end
                    else
                    begin
                        res.kind   = spct_pkg::KIND_DROPPED;
                        res.stream = sid_reg;
                    end
                end
            end

            spct_pkg::ST_CHECK:
            begin
                // Read slot i+1 while slot i is written back and reported.
                can_emit = rd_pend_reg && res_ready;
                if (can_emit)
                begin
                    res_valid        = 1'b1;
                    res.slot         = rd_slot_ext[3:0];
                    res.last         = is_last;
                    ram_wr_en        = 1'b1;
                    ram_wr_data.prev = ent.cnt;
                    if (ent.sid == '0)
                    begin
                        res.kind = spct_pkg::KIND_EMPTY;
                    end
                    else if (delta == '0)
                    begin
                        res.kind        = spct_pkg::KIND_REMOVED;
                        res.stream      = ent.sid;
                        ram_wr_data.sid = '0;
                    end
                    else
                    begin
                        res.kind   = spct_pkg::KIND_REPORT;
                        res.stream = ent.sid;
                        res.delta  = delta;
                    end
                    if (is_last)
                    begin
                        state_next = spct_pkg::ST_IDLE;
                    end
                end
                if (issue_reg < NUM_SLOTS && (!rd_pend_reg || can_emit))
                begin
                    ram_rd_en  = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                if (ram_rd_en)
                begin
                    rd_pend_next = 1'b1;
                end
                else if (can_emit)
                begin
                    rd_pend_next = 1'b0;
                end
            end

            default:
            begin
                state_next = spct_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the stream packet count table with slot aging.
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_SLOTS = spct_pkg::SLOTS_DEFAULT;
    localparam int POOL_SIZE = 24;
    localparam int PHASE_ITEMS = 50;

    // One pending input transaction.
    typedef struct {
        spct_pkg::action_t             act;
        logic [spct_pkg::STREAM_W-1:0] sid;
    } stream_req_t;

    logic                            clk;
    logic                            rst_n;
    logic                            req_valid;
    logic                            req_stall;
    logic                            action;
    logic [spct_pkg::STREAM_W-1:0]   stream_id;
    logic                            rsp_valid;
    logic                            rsp_stall;
    logic [spct_pkg::KIND_W-1:0]     kind;
    logic [spct_pkg::SLOT_OUT_W-1:0] slot;
    logic [spct_pkg::STREAM_W-1:0]   slot_stream;
    logic [spct_pkg::COUNT_W-1:0]    count_delta;
    logic                            last;

    stream_packet_count_table #(
        .SLOTS(NUM_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .action(action),
        .stream_id(stream_id),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .kind(kind),
        .slot(slot),
        .slot_stream(slot_stream),
        .count_delta(count_delta),
        .last(last)
    );

    // Shadow copy of the flow table, updated in acceptance order.
    logic [spct_pkg::STREAM_W-1:0] flow_sid [NUM_SLOTS];
    logic [spct_pkg::COUNT_W-1:0]  flow_cnt [NUM_SLOTS];
    logic [spct_pkg::COUNT_W-1:0]  flow_prev [NUM_SLOTS];

    stream_req_t       pending_reqs[$];
    spct_pkg::result_t expected_results[$];

    logic [spct_pkg::STREAM_W-1:0] id_pool [POOL_SIZE];

    int  idle_pct;
    int  stall_pct;
    int  queued_count;
    int  accepted_count;
    int  error_count;
    logic req_fire;

    // Free-running clock with a 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every input is known from time zero. Reset is held from time zero and
    // released at a falling edge, away from the sampling edge.
    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        action    = 1'b0;
        stream_id = '0;
        rsp_stall = 1'b0;
        req_fire  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Updates the shadow table for one accepted transaction and queues the
    // results it must produce. A packet gives exactly one result; a check gives
    // one result per slot, the last of them flagged.
    function automatic void predict_flow_results(spct_pkg::action_t act,
                                                 logic [spct_pkg::STREAM_W-1:0] sid);
        spct_pkg::result_t res;
        bit      matched;
        bit      have_free;
        int      free_idx;
        int      hit_idx;
        logic [spct_pkg::COUNT_W-1:0]  delta;
        logic [spct_pkg::STREAM_W-1:0] held;

        res.delta = '0;
        res.last  = 1'b1;
        if (act == spct_pkg::ACT_PACKET)
        begin
            matched   = 1'b0;
            have_free = 1'b0;
            free_idx  = 0;
            hit_idx   = 0;
            // The lowest matching slot wins; the highest free slot is claimed.
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (!matched)
                begin
                    if (flow_sid[i] == sid)
                    begin
                        matched = 1'b1;
                        hit_idx = i;
                    end
                    else if (flow_sid[i] == '0)
                    begin
                        have_free = 1'b1;
                        free_idx  = i;
                    end
                end
            end
            if (sid == '0)
            begin
                res.kind   = spct_pkg::KIND_IGNORED;
                res.slot   = '0;
                res.stream = '0;
            end
            else if (matched)
            begin
                flow_cnt[hit_idx] = flow_cnt[hit_idx] + 1'b1;
                res.kind   = spct_pkg::KIND_COUNTED;
                res.slot   = hit_idx[spct_pkg::SLOT_OUT_W-1:0];
                res.stream = sid;
            end
            else if (!have_free)
            begin
                res.kind   = spct_pkg::KIND_DROPPED;
                res.slot   = '0;
                res.stream = sid;
            end
            else
            begin
                flow_sid[free_idx]  = sid;
                flow_cnt[free_idx]  = 1;
                flow_prev[free_idx] = '0;
                res.kind   = spct_pkg::KIND_ADDED;
                res.slot   = free_idx[spct_pkg::SLOT_OUT_W-1:0];
                res.stream = sid;
            end
            expected_results.push_back(res);
        end
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                delta        = flow_cnt[i] - flow_prev[i];
                held         = flow_sid[i];
                flow_prev[i] = flow_cnt[i];
                res.slot     = i[spct_pkg::SLOT_OUT_W-1:0];
                res.last     = (i == NUM_SLOTS - 1);
                res.stream   = held;
                res.delta    = '0;
                if (held == '0)
                begin
                    res.kind = spct_pkg::KIND_EMPTY;
                end
                else if (delta == '0)
                begin
                    // Idle since the previous check, so the flow ages out.
                    flow_sid[i] = '0;
                    res.kind    = spct_pkg::KIND_REMOVED;
                end
                else
                begin
                    res.kind  = spct_pkg::KIND_REPORT;
                    res.delta = delta;
                end
                expected_results.push_back(res);
            end
        end
    endfunction

    task automatic check_field(string fname, logic [spct_pkg::STREAM_W-1:0] exp_v,
                               logic [spct_pkg::STREAM_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, exp_v, got_v);
            error_count++;
        end
    endtask

    // Monitor: samples both channels at the rising edge. Results are compared
    // before the request of the same edge is predicted, although a result can
    // never belong to a request accepted at that very edge.
    always @(posedge clk)
    begin
        spct_pkg::result_t exp_res;

        if (!rst_n)
        begin
            req_fire <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction: kind %0d slot %0d stream %0h",
                             $time, kind, slot, slot_stream);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    check_field("kind", exp_res.kind, kind);
                    check_field("slot", exp_res.slot, slot);
                    check_field("slot_stream", exp_res.stream, slot_stream);
                    check_field("count_delta", exp_res.delta, count_delta);
                    check_field("last", exp_res.last, last);
                end
            end
            if (req_valid && !req_stall)
            begin
                predict_flow_results(spct_pkg::action_t'(action), stream_id);
                accepted_count++;
            end
            req_fire <= req_valid && !req_stall;
        end
    end

    // Driver: works at the falling edge. A new transaction is offered only when
    // the previous one has gone, so a stalled payload stays put; the decision to
    // idle never looks at the stall signal.
    always @(negedge clk)
    begin
        stream_req_t nxt;

        if (rst_n)
        begin
            if (!req_valid || req_fire)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    nxt = pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    action    <= nxt.act;
                    stream_id <= nxt.sid;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic logic [spct_pkg::STREAM_W-1:0] random_stream_id();
        logic [spct_pkg::STREAM_W-1:0] sid;

        sid = {$urandom, $urandom};
        if (sid == '0)
            sid = 64'd1;
        return sid;
    endfunction

    task automatic queue_req(spct_pkg::action_t act, logic [spct_pkg::STREAM_W-1:0] sid);
        stream_req_t item;

        item.act = act;
        item.sid = sid;
        pending_reqs.push_back(item);
        queued_count++;
    endtask

    // Random traffic for one phase. It runs in episodes: a burst of packets
    // drawn from a window of the flow pool, then one or two checks. Windows
    // wider than the table can force drops; flows left out of a burst age out.
    task automatic queue_random_phase(int n_items);
        int added;
        int span;
        int burst;
        int r;

        added = 0;
        while (added < n_items)
        begin
            span  = $urandom_range(2, POOL_SIZE);
            burst = $urandom_range(4, 40);
            for (int b = 0; b < burst; b++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    queue_req(spct_pkg::ACT_PACKET, '0);
                else if (r < 9)
                    queue_req(spct_pkg::ACT_PACKET, random_stream_id());
                else
                    queue_req(spct_pkg::ACT_PACKET, id_pool[$urandom_range(0, span - 1)]);
            end
            // The identifier field of a check carries noise that must be ignored.
            queue_req(spct_pkg::ACT_CHECK, {$urandom, $urandom});
            added += burst + 1;
            if ($urandom_range(0, 3) == 0)
            begin
                queue_req(spct_pkg::ACT_CHECK, {$urandom, $urandom});
                added++;
            end
            id_pool[$urandom_range(0, POOL_SIZE - 1)] = random_stream_id();
        end
    endtask

    task automatic wait_all_accepted();
        while (pending_reqs.size() != 0 || accepted_count != queued_count)
            @(posedge clk);
    endtask

    // Stimulus and end of run.
    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            flow_sid[i]  = '0;
            flow_cnt[i]  = '0;
            flow_prev[i] = '0;
        end
        idle_pct       = 0;
        stall_pct      = 0;
        queued_count   = 0;
        accepted_count = 0;
        error_count    = 0;

        id_pool[0] = '1;
        id_pool[1] = 64'd1;
        id_pool[2] = 64'h8000_0000_0000_0000;
        id_pool[3] = 64'hAAAA_AAAA_AAAA_AAAA;
        id_pool[4] = 64'h5555_5555_5555_5555;
        for (int i = 5; i < POOL_SIZE; i++)
            id_pool[i] = random_stream_id();

        // Directed part. A zero identifier is ignored, the two extreme
        // identifiers are added and one is counted again. The first check sees
        // two reports among empty slots; the second removes both idle flows.
        queue_req(spct_pkg::ACT_PACKET, '0);
        queue_req(spct_pkg::ACT_PACKET, '1);
        queue_req(spct_pkg::ACT_PACKET, 64'd1);
        queue_req(spct_pkg::ACT_PACKET, '1);
        queue_req(spct_pkg::ACT_CHECK, '0);
        queue_req(spct_pkg::ACT_CHECK, '1);
        // Fill every slot with distinct flows, then overflow the full table.
        for (int i = 0; i < NUM_SLOTS; i++)
            queue_req(spct_pkg::ACT_PACKET, id_pool[i]);
        queue_req(spct_pkg::ACT_PACKET, id_pool[NUM_SLOTS]);
        queue_req(spct_pkg::ACT_CHECK, '1);

        // Random part across the idling phases: none, sender idle, receiver
        // stalling, then both together.
        queue_random_phase(PHASE_ITEMS);
        wait_all_accepted();

        @(posedge clk);
        idle_pct  = 51;
        stall_pct = 0;
        queue_random_phase(PHASE_ITEMS);
        wait_all_accepted();

        @(posedge clk);
        idle_pct  = 0;
        stall_pct = 51;
        queue_random_phase(PHASE_ITEMS);
        wait_all_accepted();

        @(posedge clk);
        idle_pct  = 21;
        stall_pct = 21;
        queue_random_phase(PHASE_ITEMS);
        wait_all_accepted();

        // Drain the outstanding results, then leave room for any stray extra
        // transaction to show up and be flagged by the monitor.
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (NUM_SLOTS + 8) @(negedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
